@@ sv/gse_pkg.sv @@
package gse_pkg;

  // Configuration register indexes.
  localparam logic [1:0] REG_BIAS_LIMIT  = 2'd0;
  localparam logic [1:0] REG_NOISE_LIMIT = 2'd1;
  localparam logic [1:0] REG_SENSITIVITY = 2'd2;

  localparam logic [14:0] BIAS_LIMIT_RST  = 15'd320;
  localparam logic [30:0] NOISE_LIMIT_RST = 31'd6400;
  localparam logic [7:0]  SENSITIVITY_RST = 8'd16;

  // Scale factor of the mean square, and the boundary between the two ways of forming it.
  localparam logic [13:0] TEN_K        = 14'd10000;
  localparam logic [30:0] SMALL_SUM_MAX = 31'd10000;
  localparam logic [31:0] OVF_SQUARE   = 32'h8000_0000;

  // Reciprocal of three scaled by 2^32, rounded up. A 31-bit count times this value,
  // shifted right by 32, is the count divided by three.
  localparam logic [30:0] THIRD_RECIP = 31'h5555_5556;

  localparam logic [1:0] LAST_AXIS = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_THR,
    ST_AXIS,
    ST_QDIV_WAIT,
    ST_SCALE,
    ST_SQRT_WAIT,
    ST_RMS_WAIT,
    ST_BIAS_WAIT,
    ST_DONE
  } gse_state_e;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [30:0] divisor;
  } div_req_t;

  // Magnitude of a 16-bit two's complement value; the most negative value needs 17 bits.
  function automatic logic [16:0] abs16(input logic [15:0] v);
    logic [16:0] ext;
    ext = {v[15], v};
    return v[15] ? (17'd0 - ext) : ext;
  endfunction

endpackage

@@ sv/gse_divider.sv @@
module gse_divider (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  gse_pkg::div_req_t   req_i,
  output logic                done_o,
  output logic [31:0]         quotient_o
);

  logic        busy_q;
  logic        done_q;
  logic [4:0]  cnt_q;
  logic [31:0] dvd_q;
  logic [30:0] rem_q;
  logic [30:0] dvs_q;

  logic [31:0] rem_sh;
  logic        fits;
  logic [31:0] rem_sub;

  // One restoring step per cycle; the quotient bits shift into the dividend register.
  assign rem_sh  = {rem_q, dvd_q[31]};
  assign fits    = rem_sh >= {1'b0, dvs_q};
  assign rem_sub = rem_sh - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= 5'd31;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == 5'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvd_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[30:0], fits};
      rem_q <= fits ? rem_sub[30:0] : rem_sh[30:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = dvd_q;

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q)
    else $error("divider started while a division is running");

endmodule

@@ sv/gse_isqrt.sv @@
module gse_isqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] x_i,
  output logic        done_o,
  output logic [15:0] root_o
);

  logic        busy_q;
  logic        done_q;
  logic [31:0] x_q;
  logic [31:0] res_q;
  logic [31:0] bit_q;

  logic [31:0] trial;
  logic        take;

  assign trial = res_q + bit_q;
  assign take  = x_q >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && bit_q[0]) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  // Sixteen digit steps, the trial bit walking down by two places each cycle.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q   <= x_i;
      res_q <= '0;
      bit_q <= 32'h4000_0000;
    end else if (busy_q) begin
      if (take) begin
        x_q   <= x_q - trial;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign done_o = done_q;
  assign root_o = res_q[15:0];

endmodule

@@ sv/gyro_selftest_evaluator_unit.sv @@
// Channel    | Direction | Ports                                        | Handshake
// -----------+-----------+----------------------------------------------+----------------------
// report     | in        | sample_count_i, mean_*_i, sq_sum_*_i         | start_i while !busy_o
// result     | out       | fail_mask_o, bias/rms_mdps_*_o, cal_*_o,     | done_o, one cycle
//            |           | count_per_axis_o                             |
// config     | in        | cfg_index_i, cfg_data_i                      | cfg_valid_i/cfg_ready_o
//
// busy_o stays high from the accepting edge to the last cycle of ST_DONE, and done_o follows in the next one.
// The shared 32-step divider runs up to nine times (per axis the mean square, the RMS scaling
// and the bias scaling) beside a 16-step square root per axis; an axis whose sum is zero or
// negative skips its mean-square division. The next start may be given in the strobe cycle.
// Reset is asynchronous and active low; it loads the configuration defaults and idles the
// sequencer. The receiver cannot stall: done_o lasts one cycle.
module gyro_selftest_evaluator_unit (
  input  logic               clk_i,
  input  logic               rst_ni,

  input  logic               start_i,
  output logic               busy_o,
  input  logic [30:0]        sample_count_i,
  input  logic signed [15:0] mean_x_i,
  input  logic signed [15:0] mean_y_i,
  input  logic signed [15:0] mean_z_i,
  input  logic signed [31:0] sq_sum_x_i,
  input  logic signed [31:0] sq_sum_y_i,
  input  logic signed [31:0] sq_sum_z_i,

  output logic               done_o,
  output logic [6:0]         fail_mask_o,
  output logic signed [25:0] bias_mdps_x_o,
  output logic signed [25:0] bias_mdps_y_o,
  output logic signed [25:0] bias_mdps_z_o,
  output logic [19:0]        rms_mdps_x_o,
  output logic [19:0]        rms_mdps_y_o,
  output logic [19:0]        rms_mdps_z_o,
  output logic signed [15:0] cal_x_o,
  output logic signed [15:0] cal_y_o,
  output logic signed [15:0] cal_z_o,
  output logic [29:0]        count_per_axis_o,

  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  // Configuration registers. The user must see they are written only while no report is in flight; unchecked.
  logic [14:0] bias_limit_q;
  logic [30:0] noise_limit_q;
  logic [7:0]  sens_q;
  logic [7:0]  sens_eff;

  assign cfg_ready_o = 1'b1;
  assign sens_eff    = (sens_q == 8'd0) ? 8'd1 : sens_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bias_limit_q  <= gse_pkg::BIAS_LIMIT_RST;
      noise_limit_q <= gse_pkg::NOISE_LIMIT_RST;
      sens_q        <= gse_pkg::SENSITIVITY_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        gse_pkg::REG_BIAS_LIMIT:  bias_limit_q  <= cfg_data_i[14:0];
        gse_pkg::REG_NOISE_LIMIT: noise_limit_q <= cfg_data_i[30:0];
        gse_pkg::REG_SENSITIVITY: sens_q        <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Report capture.
  logic        accept;
  logic [30:0] raw_count_q;
  logic [30:0] count_q;
  logic [15:0] mean_q [3];
  logic [31:0] sum_q  [3];

  gse_pkg::gse_state_e state_q, state_d;

  assign busy_o = (state_q != gse_pkg::ST_IDLE);
  assign accept = start_i && !busy_o;

  // Sequencer outputs to the shared units.
  gse_pkg::div_req_t div_req;
  logic        div_done;
  logic [31:0] quot;
  logic        sqrt_start;
  logic [31:0] sqrt_x;
  logic        sqrt_done;
  logic [15:0] root;

  // The shared multiplier: every product apart from the count reciprocal is some value times ten thousand.
  logic [31:0] mul_a;
  logic [45:0] mul_p;
  assign mul_p = 46'(mul_a) * 46'(gse_pkg::TEN_K);

  // The count divided by three comes from a reciprocal multiply, exact for any 31-bit count.
  logic [61:0] third_p;
  assign third_p = 62'(raw_count_q) * 62'(gse_pkg::THIRD_RECIP);

  logic [1:0]  axis_q;
  logic        small_q;
  logic [45:0] thr_q;
  logic        dead_q;
  logic        noise_q [3];

  logic [31:0] sum_sel;
  logic [15:0] mean_sel;
  logic [16:0] mean_abs;
  logic [31:0] mean_x1000;
  logic        sum_neg;
  logic        sum_zero;
  logic        sum_small;
  logic        noise_flag;

  assign sum_sel    = sum_q[axis_q];
  assign mean_sel   = mean_q[axis_q];
  assign mean_abs   = gse_pkg::abs16(mean_sel);
  assign mean_x1000 = (32'(mean_abs) << 10) - (32'(mean_abs) << 4) - (32'(mean_abs) << 3);
  assign sum_neg    = sum_sel[31];
  assign sum_zero   = (sum_sel == 32'd0);
  assign sum_small  = (sum_sel[30:0] <= gse_pkg::SMALL_SUM_MAX);

  // For a small sum the divider returns sum*10000/count, so the noise test against the
  // limit becomes a test against (limit+1)*10000. A large sum divides plainly.
  assign noise_flag = small_q ? ({14'd0, quot} >= thr_q) : (quot > {1'b0, noise_limit_q});

  always_comb begin
    state_d          = state_q;
    div_req.start    = 1'b0;
    div_req.dividend = {1'b0, raw_count_q};
    div_req.divisor  = count_q;
    sqrt_start       = 1'b0;
    sqrt_x           = '0;
    mul_a            = sum_sel;
    case (state_q)
      gse_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = gse_pkg::ST_THR;
        end
      end
      gse_pkg::ST_THR: begin
        mul_a   = {1'b0, noise_limit_q} + 32'd1;
        state_d = gse_pkg::ST_AXIS;
      end
      gse_pkg::ST_AXIS: begin
        if (sum_neg) begin
          sqrt_start = 1'b1;
          sqrt_x     = gse_pkg::OVF_SQUARE;
          state_d    = gse_pkg::ST_SQRT_WAIT;
        end else if (sum_zero) begin
          sqrt_start = 1'b1;
          sqrt_x     = '0;
          state_d    = gse_pkg::ST_SQRT_WAIT;
        end else begin
          mul_a            = sum_sel;
          div_req.start    = 1'b1;
          div_req.dividend = sum_small ? mul_p[31:0] : sum_sel;
          div_req.divisor  = count_q;
          state_d          = gse_pkg::ST_QDIV_WAIT;
        end
      end
      gse_pkg::ST_QDIV_WAIT: begin
        if (div_done) begin
          state_d = gse_pkg::ST_SCALE;
        end
      end
      gse_pkg::ST_SCALE: begin
        mul_a      = quot;
        sqrt_start = 1'b1;
        sqrt_x     = small_q ? quot : mul_p[31:0];
        state_d    = gse_pkg::ST_SQRT_WAIT;
      end
      gse_pkg::ST_SQRT_WAIT: begin
        if (sqrt_done) begin
          div_req.start    = 1'b1;
          div_req.dividend = {16'd0, root};
          div_req.divisor  = {23'd0, sens_eff};
          state_d          = gse_pkg::ST_RMS_WAIT;
        end
      end
      gse_pkg::ST_RMS_WAIT: begin
        if (div_done) begin
          div_req.start    = 1'b1;
          div_req.dividend = mean_x1000;
          div_req.divisor  = {23'd0, sens_eff};
          state_d          = gse_pkg::ST_BIAS_WAIT;
        end
      end
      gse_pkg::ST_BIAS_WAIT: begin
        if (div_done) begin
          state_d = (axis_q == gse_pkg::LAST_AXIS) ? gse_pkg::ST_DONE : gse_pkg::ST_AXIS;
        end
      end
      gse_pkg::ST_DONE: begin
        state_d = gse_pkg::ST_IDLE;
      end
      default: begin
        state_d = gse_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gse_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Result registers. Bias and RMS are filled axis by axis, and all of them hold still through the strobe.
  logic        done_q;
  logic [6:0]  mask_q;
  logic [25:0] bias_q [3];
  logic [19:0] rms_q  [3];
  logic [15:0] cal_q  [3];
  logic [29:0] cpa_q;
  logic [6:0]  mask_d;

  always_comb begin
    mask_d = {noise_q[2], noise_q[1], noise_q[0], dead_q, 3'b000};
    for (int j = 0; j < 3; j++) begin
      mask_d[j] = gse_pkg::abs16(mean_q[j]) > {2'b00, bias_limit_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= (state_q == gse_pkg::ST_DONE);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      raw_count_q <= sample_count_i;
      count_q     <= (sample_count_i == 31'd0) ? 31'd1 : sample_count_i;
      mean_q[0]   <= mean_x_i;
      mean_q[1]   <= mean_y_i;
      mean_q[2]   <= mean_z_i;
      sum_q[0]    <= sq_sum_x_i;
      sum_q[1]    <= sq_sum_y_i;
      sum_q[2]    <= sq_sum_z_i;
      dead_q      <= 1'b0;
      axis_q      <= '0;
    end
    case (state_q)
      gse_pkg::ST_THR: begin
        thr_q <= mul_p;
        cpa_q <= third_p[61:32];
      end
      gse_pkg::ST_AXIS: begin
        small_q <= sum_small;
        if (sum_neg || sum_zero) begin
          noise_q[axis_q] <= 1'b0;
        end
        if (sum_zero) begin
          dead_q <= 1'b1;
        end
      end
      gse_pkg::ST_SCALE: begin
        noise_q[axis_q] <= noise_flag;
      end
      gse_pkg::ST_RMS_WAIT: begin
        if (div_done) begin
          rms_q[axis_q] <= 20'((quot << 3) + (quot << 1));
        end
      end
      gse_pkg::ST_BIAS_WAIT: begin
        if (div_done) begin
          bias_q[axis_q] <= mean_sel[15] ? 26'(32'd0 - quot) : quot[25:0];
          axis_q         <= axis_q + 2'd1;
        end
      end
      gse_pkg::ST_DONE: begin
        mask_q <= mask_d;
        for (int j = 0; j < 3; j++) begin
          cal_q[j] <= (mask_d != 7'd0) ? 16'd0 : mean_q[j];
        end
      end
      default: ;
    endcase
  end

  gse_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .done_o     (div_done),
    .quotient_o (quot)
  );

  gse_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .x_i     (sqrt_x),
    .done_o  (sqrt_done),
    .root_o  (root)
  );

  assign done_o           = done_q;
  assign fail_mask_o      = mask_q;
  assign bias_mdps_x_o    = bias_q[0];
  assign bias_mdps_y_o    = bias_q[1];
  assign bias_mdps_z_o    = bias_q[2];
  assign rms_mdps_x_o     = rms_q[0];
  assign rms_mdps_y_o     = rms_q[1];
  assign rms_mdps_z_o     = rms_q[2];
  assign cal_x_o          = cal_q[0];
  assign cal_y_o          = cal_q[1];
  assign cal_z_o          = cal_q[2];
  assign count_per_axis_o = cpa_q;

  // An accepted report always keeps the block busy in the following cycle.
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_o)
    else $error("report accepted but block not busy");

  // Exactly one result transaction per report: the strobe never stays high in consecutive cycles.
  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for more than one cycle");

  // A failing report never hands out calibration offsets.
  a_no_cal_on_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (fail_mask_o != 7'd0)) |-> (cal_x_o == 16'sd0 && cal_y_o == 16'sd0 &&
                                           cal_z_o == 16'sd0))
    else $error("calibration offsets given on a failing report");

endmodule

@@ test/gyro_selftest_evaluator_unit_test.sv @@
module gyro_selftest_evaluator_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  // REPORT_CYCLES covers the work of one report. The settle time at the end and the run-time limit
  // are sized from it. The limit assumes every report waits out the longest sender gap, and then
  // adds a wide margin.
  localparam int unsigned REPORT_CYCLES    = 400;
  localparam int unsigned CYCLE_LIMIT      = 8_000_000;
  localparam int unsigned SETTING_COUNT    = 7;
  localparam int unsigned RANDOM_PER_SETUP = 250;
  localparam int unsigned PRINT_CAP        = 200;
  localparam int unsigned DIRECTED_COUNT   = 14;

  // A self-test report as the sender presents it.
  typedef struct packed {
    logic [30:0]        count;
    logic signed [15:0] mean_x;
    logic signed [15:0] mean_y;
    logic signed [15:0] mean_z;
    logic signed [31:0] sq_x;
    logic signed [31:0] sq_y;
    logic signed [31:0] sq_z;
  } report_t;

  // The evaluation that the block returns for one report.
  typedef struct packed {
    logic [6:0]         mask;
    logic signed [25:0] bias_x;
    logic signed [25:0] bias_y;
    logic signed [25:0] bias_z;
    logic [19:0]        rms_x;
    logic [19:0]        rms_y;
    logic [19:0]        rms_z;
    logic signed [15:0] cal_x;
    logic signed [15:0] cal_y;
    logic signed [15:0] cal_z;
    logic [29:0]        per_axis;
  } verdict_t;

  // A row of the directed table. When typed is set, the expected verdict is the one written
  // in the row. Otherwise the predictor works it out.
  typedef struct packed {
    report_t  rep;
    bit       typed;
    verdict_t want;
  } row_t;

  // All rows run under the reset values: bias limit 320, noise limit 6400, sensitivity 16.
  localparam row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
    // Empty report with a zero count. Every sum is zero, so the part is dead.
    '{'{31'd0, 16'sd0, 16'sd0, 16'sd0, 32'sd0, 32'sd0, 32'sd0}, 1'b1,
      '{7'h08, 26'sd0, 26'sd0, 26'sd0, 20'd0, 20'd0, 20'd0,
        16'sd0, 16'sd0, 16'sd0, 30'd0}},
    // Overflowed sums on every axis. The mean square is forced to 2^31, and no noise flag
    // is raised.
    '{'{31'd1, 16'sd0, 16'sd0, 16'sd0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000},
      1'b1,
      '{7'h00, 26'sd0, 26'sd0, 26'sd0, 20'd28960, 20'd28960, 20'd28960,
        16'sd0, 16'sd0, 16'sd0, 30'd0}},
    // Largest count and largest sums.
    '{'{31'h7FFF_FFFF, 16'sd0, 16'sd0, 16'sd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
        32'h7FFF_FFFF}, 1'b1,
      '{7'h00, 26'sd0, 26'sd0, 26'sd0, 20'd60, 20'd60, 20'd60,
        16'sd0, 16'sd0, 16'sd0, 30'd715827882}},
    // Extreme means. X and Y fail on bias, which clears the calibration values.
    '{'{31'd3, 16'h8000, 16'sd32767, 16'sd1, 32'sd1, 32'sd1, 32'sd1}, 1'b1,
      '{7'h03, -26'sd2048000, 26'sd2047937, 26'sd62, 20'd30, 20'd30, 20'd30,
        16'sd0, 16'sd0, 16'sd0, 30'd1}},
    // Means exactly at the bias limit, and a mean square exactly at the noise limit.
    '{'{31'd100, 16'sd320, -16'sd320, 16'sd0, 32'sd640000, 32'sd640000, 32'sd640000},
      1'b0, '0},
    // One step over both limits.
    '{'{31'd100, 16'sd321, -16'sd321, 16'sd5, 32'sd640100, 32'sd640100, 32'sd640100},
      1'b0, '0},
    // The edge between the two ways of scaling the mean square.
    '{'{31'd1, 16'sd10, 16'sd20, 16'sd30, 32'sd10000, 32'sd10001, 32'sd9999},
      1'b0, '0},
    // The scaled mean square wraps at 32 bits.
    '{'{31'd1, -16'sd5, 16'sd7, -16'sd9, 32'sd2147483647, 32'sd500000, 32'sd1},
      1'b0, '0},
    // A zero count with positive sums is divided as a count of one.
    '{'{31'd0, 16'sd1, 16'sd2, 16'sd3, 32'sd100, 32'sd20000, 32'sd6400}, 1'b0, '0},
    // A dead axis next to an overflowed one.
    '{'{31'd7, -16'sd1, 16'sd1, 16'sd0, 32'sd0, 32'sd44, -32'sd1}, 1'b0, '0},
    // A typical passing part, whose means come back as calibration offsets.
    '{'{31'd50000, 16'sd100, -16'sd100, 16'sd250, 32'sd123456789, 32'sd98765432,
        32'sd5555555}, 1'b0, '0},
    '{'{31'd2, 16'sd32767, -16'sd32767, 16'h8000, 32'sd2147483647, -32'sd2, 32'sd10000},
      1'b0, '0},
    // Only Y is over the noise limit.
    '{'{31'd1000, 16'sd0, 16'sd0, 16'sd0, 32'sd6400000, 32'sd6401000, 32'sd6399999},
      1'b0, '0},
    '{'{31'd3, -16'sd17, 16'sd17, -16'sd16, 32'sd3, 32'sd30003, 32'sd300}, 1'b0, '0}
  };

  logic               clk_i;
  logic               rst_ni;
  logic               start_i;
  logic               busy_o;
  logic [30:0]        sample_count_i;
  logic signed [15:0] mean_x_i;
  logic signed [15:0] mean_y_i;
  logic signed [15:0] mean_z_i;
  logic signed [31:0] sq_sum_x_i;
  logic signed [31:0] sq_sum_y_i;
  logic signed [31:0] sq_sum_z_i;
  logic               done_o;
  logic [6:0]         fail_mask_o;
  logic signed [25:0] bias_mdps_x_o;
  logic signed [25:0] bias_mdps_y_o;
  logic signed [25:0] bias_mdps_z_o;
  logic [19:0]        rms_mdps_x_o;
  logic [19:0]        rms_mdps_y_o;
  logic [19:0]        rms_mdps_z_o;
  logic signed [15:0] cal_x_o;
  logic signed [15:0] cal_y_o;
  logic signed [15:0] cal_z_o;
  logic [29:0]        count_per_axis_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [1:0]         cfg_index_i;
  logic [31:0]        cfg_data_i;

  // The testbench keeps its own copy of the limits. It is updated only when a register
  // write completes its transaction.
  logic [14:0] bias_cfg;
  logic [30:0] noise_cfg;
  logic [7:0]  sens_cfg;

  verdict_t    pending_verdicts[$];
  int unsigned mismatch_count;
  int unsigned reports_checked;
  int unsigned reports_flagged;
  int unsigned cycle_count;
  bit          quiet_stretch;

  gyro_selftest_evaluator_unit i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .sample_count_i   (sample_count_i),
    .mean_x_i         (mean_x_i),
    .mean_y_i         (mean_y_i),
    .mean_z_i         (mean_z_i),
    .sq_sum_x_i       (sq_sum_x_i),
    .sq_sum_y_i       (sq_sum_y_i),
    .sq_sum_z_i       (sq_sum_z_i),
    .done_o           (done_o),
    .fail_mask_o      (fail_mask_o),
    .bias_mdps_x_o    (bias_mdps_x_o),
    .bias_mdps_y_o    (bias_mdps_y_o),
    .bias_mdps_z_o    (bias_mdps_z_o),
    .rms_mdps_x_o     (rms_mdps_x_o),
    .rms_mdps_y_o     (rms_mdps_y_o),
    .rms_mdps_z_o     (rms_mdps_z_o),
    .cal_x_o          (cal_x_o),
    .cal_y_o          (cal_y_o),
    .cal_z_o          (cal_z_o),
    .count_per_axis_o (count_per_axis_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // Floor of the square root, found one result bit at a time from the top. The root of a
  // 32-bit value fits in 16 bits.
  function automatic int unsigned floor_root(logic [31:0] v);
    longint unsigned root;
    longint unsigned trial;
    int              b;
    root = 0;
    for (b = 15; b >= 0; b--) begin
      trial = root | (longint'(1) << b);
      if (trial * trial <= longint'(v)) begin
        root = trial;
      end
    end
    return int'(root);
  endfunction

  // Works out the verdict for one report under the current limits.
  function automatic verdict_t predict_verdict(report_t r);
    verdict_t        v;
    longint unsigned cnt;
    longint unsigned pos_sum;
    longint          divisor;
    longint          m[3];
    longint          s[3];
    longint          bias[3];
    longint          rms[3];
    longint          mag;
    logic [31:0]     mean_sq;
    int              ax;
    // A zero count or a zero sensitivity is divided as one.
    cnt     = (r.count == 0) ? 1 : longint'(r.count);
    divisor = (sens_cfg == 0) ? 1 : longint'(sens_cfg);
    m[0] = r.mean_x;
    m[1] = r.mean_y;
    m[2] = r.mean_z;
    s[0] = r.sq_x;
    s[1] = r.sq_y;
    s[2] = r.sq_z;
    v = '0;
    for (ax = 0; ax < 3; ax++) begin
      mag = (m[ax] < 0) ? -m[ax] : m[ax];
      if (mag > longint'(bias_cfg)) begin
        v.mask[ax] = 1'b1;
      end
      if (s[ax] == 0) begin
        v.mask[3] = 1'b1;
      end
      pos_sum = (s[ax] > 0) ? longint'(s[ax]) : 0;
      if (s[ax] > 0 && pos_sum / cnt > longint'(noise_cfg)) begin
        v.mask[4 + ax] = 1'b1;
      end
      // A large sum is divided before it is scaled, so that the product can wrap. A small
      // sum is scaled first, which keeps its fraction.
      if (s[ax] < 0) begin
        mean_sq = 32'h8000_0000;
      end else if (s[ax] > 10000) begin
        mean_sq = 32'((pos_sum / cnt) * 10000);
      end else begin
        mean_sq = 32'((pos_sum * 10000) / cnt);
      end
      bias[ax] = (m[ax] * 1000) / divisor;
      rms[ax]  = (longint'(floor_root(mean_sq)) / divisor) * 10;
    end
    v.bias_x   = 26'(bias[0]);
    v.bias_y   = 26'(bias[1]);
    v.bias_z   = 26'(bias[2]);
    v.rms_x    = 20'(rms[0]);
    v.rms_y    = 20'(rms[1]);
    v.rms_z    = 20'(rms[2]);
    // The calibration offsets are the means only when the part passes.
    v.cal_x    = (v.mask == 0) ? r.mean_x : 16'sd0;
    v.cal_y    = (v.mask == 0) ? r.mean_y : 16'sd0;
    v.cal_z    = (v.mask == 0) ? r.mean_z : 16'sd0;
    v.per_axis = 30'(r.count / 3);
    return v;
  endfunction

  // Sender gaps. Most are short. A few are long enough to reach past the end of the
  // block's work, so that the next report lands anywhere in the sequencing.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (quiet_stretch || roll < 55) begin
      return 0;
    end else if (roll < 85) begin
      return $urandom_range(1, 6);
    end else if (roll < 96) begin
      return $urandom_range(7, 60);
    end
    return $urandom_range(61, 600);
  endfunction

  // A signed magnitude around the bias limit. Most values lie inside the limit, so that
  // passing parts, and with them the calibration offsets, show up often.
  function automatic logic signed [15:0] pick_mean();
    longint mag;
    longint top;
    top = longint'(bias_cfg);
    if ($urandom_range(0, 99) < 85) begin
      mag = longint'($urandom_range(0, int'(top)));
    end else begin
      mag = longint'($urandom_range(0, int'(top + top / 8 + 2)));
    end
    if (mag > 32768) begin
      mag = 32768;
    end
    if ($urandom_range(0, 1) == 1) begin
      return 16'(-mag);
    end
    return (mag > 32767) ? 16'sd32767 : 16'(mag);
  endfunction

  // A sum of squares whose mean square sits near the noise limit, with some dead and some
  // overflowed axes mixed in.
  function automatic logic signed [31:0] pick_sum(longint cnt);
    longint      ms;
    longint      sum;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      return 32'sd0;
    end else if (roll < 6) begin
      return 32'($urandom) | 32'h8000_0000;
    end else if (roll < 12) begin
      // Right on the noise limit, or one count above it.
      ms = longint'(noise_cfg) * cnt + (($urandom_range(0, 1) == 1) ? cnt : 0);
      sum = ms;
    end else if (roll < 20) begin
      sum = longint'($urandom_range(1, 10001));
    end else begin
      ms  = longint'($urandom_range(0, int'(noise_cfg + noise_cfg / 8 + 1)));
      sum = ms * cnt + longint'($urandom_range(0, int'(cnt - 1)));
    end
    if (sum > 32'sh7FFF_FFFF) begin
      sum = 32'sh7FFF_FFFF;
    end
    return 32'(sum);
  endfunction

  function automatic report_t pick_report();
    report_t     r;
    longint      cnt;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 15) begin
      // Raw noise on every field.
      r.count  = 31'($urandom);
      r.mean_x = 16'($urandom);
      r.mean_y = 16'($urandom);
      r.mean_z = 16'($urandom);
      r.sq_x   = 32'($urandom);
      r.sq_y   = 32'($urandom);
      r.sq_z   = 32'($urandom);
      return r;
    end
    case ($urandom_range(0, 3))
      0:       r.count = 31'($urandom_range(1, 16));
      1:       r.count = 31'($urandom_range(17, 5000));
      2:       r.count = 31'($urandom_range(5001, 2000000));
      default: r.count = 31'($urandom);
    endcase
    if (roll < 18) begin
      r.count = 31'd0;
    end
    cnt      = (r.count == 0) ? 1 : longint'(r.count);
    r.mean_x = pick_mean();
    r.mean_y = pick_mean();
    r.mean_z = pick_mean();
    r.sq_x   = pick_sum(cnt);
    r.sq_y   = pick_sum(cnt);
    r.sq_z   = pick_sum(cnt);
    return r;
  endfunction

  // Presents one report and holds it until the block accepts it. start_i stays high when
  // the next report follows at once, so it is never lowered and raised in the same step.
  task automatic send_report(report_t r, bit typed, verdict_t want);
    sample_count_i <= r.count;
    mean_x_i       <= r.mean_x;
    mean_y_i       <= r.mean_y;
    mean_z_i       <= r.mean_z;
    sq_sum_x_i     <= r.sq_x;
    sq_sum_y_i     <= r.sq_y;
    sq_sum_z_i     <= r.sq_z;
    start_i        <= 1'b1;
    do begin
      @(posedge clk_i);
    end while (busy_o !== 1'b0);
    pending_verdicts.push_back(typed ? want : predict_verdict(r));
  endtask

  task automatic pause_sender();
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // One register write. cfg_valid_i stays high across a group of writes and is lowered
  // by the caller once the group is done.
  task automatic write_register(logic [1:0] index, logic [31:0] data);
    cfg_index_i <= index;
    cfg_data_i  <= data;
    cfg_valid_i <= 1'b1;
    do begin
      @(posedge clk_i);
    end while (cfg_ready_o !== 1'b1);
    case (index)
      gse_pkg::REG_BIAS_LIMIT:  bias_cfg  = data[14:0];
      gse_pkg::REG_NOISE_LIMIT: noise_cfg = data[30:0];
      gse_pkg::REG_SENSITIVITY: sens_cfg  = data[7:0];
      default: ;
    endcase
  endtask

  // The limits are changed only while the block is idle, that is, after every pending
  // verdict has come back.
  task automatic load_limits(logic [14:0] bias, logic [30:0] noise, logic [7:0] sens);
    start_i <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    write_register(gse_pkg::REG_BIAS_LIMIT, {17'd0, bias});
    write_register(gse_pkg::REG_NOISE_LIMIT, {1'b0, noise});
    write_register(gse_pkg::REG_SENSITIVITY, {24'd0, sens});
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic check_field(string name, logic signed [63:0] want,
                             logic signed [63:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= PRINT_CAP) begin
        $error("%s: expected %0d, actual %0d", name, want, got);
      end
    end
  endtask

  // Each result is marked by done_o for one cycle only. It is compared with the oldest
  // pending verdict at the edge that ends that cycle.
  always @(posedge clk_i) begin
    verdict_t want;
    if (rst_ni === 1'b1 && done_o === 1'b1) begin
      if (pending_verdicts.size() == 0) begin
        mismatch_count++;
        $error("result transaction with no report pending");
      end else begin
        want = pending_verdicts.pop_front();
        reports_checked++;
        if (want.mask != 0) begin
          reports_flagged++;
        end
        check_field("fail_mask", {57'd0, want.mask}, {57'd0, fail_mask_o});
        check_field("bias_mdps_x", want.bias_x, bias_mdps_x_o);
        check_field("bias_mdps_y", want.bias_y, bias_mdps_y_o);
        check_field("bias_mdps_z", want.bias_z, bias_mdps_z_o);
        check_field("rms_mdps_x", {44'd0, want.rms_x}, {44'd0, rms_mdps_x_o});
        check_field("rms_mdps_y", {44'd0, want.rms_y}, {44'd0, rms_mdps_y_o});
        check_field("rms_mdps_z", {44'd0, want.rms_z}, {44'd0, rms_mdps_z_o});
        check_field("cal_x", want.cal_x, cal_x_o);
        check_field("cal_y", want.cal_y, cal_y_o);
        check_field("cal_z", want.cal_z, cal_z_o);
        check_field("count_per_axis", {34'd0, want.per_axis}, {34'd0, count_per_axis_o});
      end
    end
  end

  // A hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int unsigned setup;
    int unsigned n;
    logic [14:0] bias;
    logic [30:0] noise;
    logic [7:0]  sens;
    mismatch_count  = 0;
    reports_checked = 0;
    reports_flagged = 0;
    cycle_count     = 0;
    quiet_stretch   = 1'b0;
    bias_cfg        = 15'd320;
    noise_cfg       = 31'd6400;
    sens_cfg        = 8'd16;
    rst_ni          = 1'b0;
    start_i         = 1'b0;
    sample_count_i  = '0;
    mean_x_i        = '0;
    mean_y_i        = '0;
    mean_z_i        = '0;
    sq_sum_x_i      = '0;
    sq_sum_y_i      = '0;
    sq_sum_z_i      = '0;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = gse_pkg::REG_BIAS_LIMIT;
    cfg_data_i      = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed reports run under the reset values of the limits.
    for (n = 0; n < DIRECTED_COUNT; n++) begin
      send_report(DIRECTED_ROWS[n].rep, DIRECTED_ROWS[n].typed, DIRECTED_ROWS[n].want);
      pause_sender();
    end

    // Random reports under a series of limit settings: the tightest, the loosest, a zero
    // sensitivity, and then a few drawn at random.
    for (setup = 0; setup < SETTING_COUNT; setup++) begin
      case (setup)
        0: begin
          bias  = 15'd0;
          noise = 31'd0;
          sens  = 8'd1;
        end
        1: begin
          bias  = 15'h7FFF;
          noise = 31'h7FFF_FFFF;
          sens  = 8'd255;
        end
        2: begin
          bias  = 15'd320;
          noise = 31'd6400;
          sens  = 8'd0;
        end
        default: begin
          bias  = ($urandom_range(0, 1) == 1) ? 15'($urandom_range(0, 1000))
                                              : 15'($urandom);
          noise = ($urandom_range(0, 1) == 1) ? 31'($urandom_range(0, 20000))
                                              : 31'($urandom);
          sens  = 8'($urandom_range(1, 255));
        end
      endcase
      load_limits(bias, noise, sens);
      for (n = 0; n < RANDOM_PER_SETUP; n++) begin
        // Now and then the sender switches to a run of back-to-back reports.
        if (n % 32 == 0) begin
          quiet_stretch = ($urandom_range(0, 3) == 0);
        end
        send_report(pick_report(), 1'b0, '0);
        pause_sender();
      end
    end

    start_i <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    // Stay a little longer to catch any stray result.
    repeat (REPORT_CYCLES) @(posedge clk_i);

    $display("Checked %0d reports under %0d limit settings; %0d flagged, %0d passed.",
             reports_checked, SETTING_COUNT + 1, reports_flagged,
             reports_checked - reports_flagged);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/gse_pkg.sv
sv/gse_divider.sv
sv/gse_isqrt.sv
sv/gyro_selftest_evaluator_unit.sv
test/gyro_selftest_evaluator_unit_test.sv
